>>> rtl/core/ps2mt_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker package
// Shared constants, register indexes, structures and the delta decoder.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

    localparam int COORD_BITS_DEF = 12;

    // Configuration register indexes and widths.
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 13;
    localparam int SENS_BITS     = 4;
    localparam int SIZE_BITS     = 13;

    localparam logic [CFG_ADDR_BITS-1:0] REG_SENSITIVITY   = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SCREEN_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SCREEN_HEIGHT = 2'd2;

    localparam logic [SENS_BITS-1:0] SENS_RESET   = 4'd1;
    localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 13'd800;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd600;

    localparam int CURSOR_X_RESET = 400;
    localparam int CURSOR_Y_RESET = 300;

    // Header byte bits.
    localparam int HDR_LEFT  = 0;
    localparam int HDR_RIGHT = 1;
    localparam int HDR_SYNC  = 3;
    localparam int HDR_XSIGN = 4;
    localparam int HDR_YSIGN = 5;
    localparam int HDR_XOVF  = 6;
    localparam int HDR_YOVF  = 7;

    // Scaled delta: 9-bit signed times 4-bit unsigned fits in 14 bits signed.
    localparam int DELTA_BITS = 14;

    typedef struct packed {
        logic [SENS_BITS-1:0] sensitivity;
        logic [SIZE_BITS-1:0] screen_width;
        logic [SIZE_BITS-1:0] screen_height;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [7:0] header;
        logic [7:0] x_move;
        logic [7:0] y_move;
    } t_packet;

    // Decodes a 9-bit delta, saturates on overflow and scales it.
    function automatic logic signed [DELTA_BITS-1:0] scaled_delta(
        input logic                 neg,
        input logic                 ovf,
        input logic [7:0]           move,
        input logic [SENS_BITS-1:0] sens
    );
        logic signed [8:0]            d;
        logic [SENS_BITS-1:0]         m;
        logic signed [DELTA_BITS-1:0] a;
        logic signed [DELTA_BITS-1:0] b;
        if (ovf) begin
            d = neg ? -9'sd255 : 9'sd255;
        end else begin
            d = $signed({neg, move});
        end
        m = (sens == '0) ? SENS_BITS'(1) : sens;
        a = $signed({{(DELTA_BITS-9){d[8]}}, d});
        b = $signed({{(DELTA_BITS-SENS_BITS){1'b0}}, m});
        return a * b;
    endfunction

endpackage

>>> rtl/core/ps2mt_cfg_regs.sv
// ----------------------------------------------------------------------------
// PS/2 mouse tracker configuration registers
// Sensitivity and screen size, written through a plain write port.
// ----------------------------------------------------------------------------
module ps2mt_cfg_regs
    import ps2mt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensitivity   <= SENS_RESET;
            r_cfg.screen_width  <= WIDTH_RESET;
            r_cfg.screen_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SENSITIVITY:   r_cfg.sensitivity   <= i_cfg_wdata[SENS_BITS-1:0];
                REG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_wdata[SIZE_BITS-1:0];
                REG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_wdata[SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/ps2mt_packet_asm.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet assembler
// Collects three auxiliary bytes into a packet, syncing on header bit 3.
// ----------------------------------------------------------------------------
module ps2mt_packet_asm
    import ps2mt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_valid,
    input  logic [7:0] i_byte,
    output t_packet    o_pkt
);

    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_X    = 2'd1,
        PH_Y    = 2'd2
    } t_phase;

    t_phase     r_phase;
    logic [7:0] r_header;
    logic [7:0] r_x_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEAD;
            r_header <= '0;
            r_x_move <= '0;
        end else if (i_byte_valid) begin
            unique case (r_phase)
                PH_X: begin
                    r_x_move <= i_byte;
                    r_phase  <= PH_Y;
                end
                PH_Y: begin
                    r_phase <= PH_HEAD;
                end
                default: begin
                    // A first byte without the sync bit is dropped.
                    if (i_byte[HDR_SYNC]) begin
                        r_header <= i_byte;
                        r_phase  <= PH_X;
                    end else begin
                        r_phase  <= PH_HEAD;
                    end
                end
            endcase
        end
    end

    assign o_pkt.valid  = i_byte_valid && (r_phase == PH_Y);
    assign o_pkt.header = r_header;
    assign o_pkt.x_move = r_x_move;
    assign o_pkt.y_move = i_byte;

endmodule

>>> rtl/core/ps2mt_cursor.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor update
// Scales the packet deltas, moves the cursor and clamps it to the screen.
// ----------------------------------------------------------------------------
module ps2mt_cursor
    import ps2mt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_packet               i_pkt,
    input  t_cfg                  i_cfg,
    output logic [COORD_BITS-1:0] o_pos_x,
    output logic [COORD_BITS-1:0] o_pos_y
);

    // Sum width: cursor plus a 14-bit signed delta, with a sign bit.
    localparam int AW   = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;
    localparam int SPAN = 1 << COORD_BITS;
    localparam logic [COORD_BITS-1:0] X_RESET =
        COORD_BITS'((CURSOR_X_RESET > SPAN - 1) ? SPAN - 1 : CURSOR_X_RESET);
    localparam logic [COORD_BITS-1:0] Y_RESET =
        COORD_BITS'((CURSOR_Y_RESET > SPAN - 1) ? SPAN - 1 : CURSOR_Y_RESET);
    localparam logic signed [AW-1:0] SPAN_W = AW'(SPAN);

    function automatic logic [COORD_BITS-1:0] clamp_pos(
        input logic signed [AW-1:0] v,
        input logic [SIZE_BITS-1:0] size
    );
        logic signed [AW-1:0] lim;
        logic signed [AW-1:0] s;
        s = $signed({{(AW-SIZE_BITS){1'b0}}, size});
        if (s < AW'(1)) begin
            lim = AW'(1);
        end else if (s > SPAN_W) begin
            lim = SPAN_W;
        end else begin
            lim = s;
        end
        if (v < 0) begin
            return '0;
        end else if (v >= lim) begin
            return COORD_BITS'(lim - AW'(1));
        end else begin
            return v[COORD_BITS-1:0];
        end
    endfunction

    logic [COORD_BITS-1:0]        r_cur_x;
    logic [COORD_BITS-1:0]        r_cur_y;
    logic [COORD_BITS-1:0]        n_cur_x;
    logic [COORD_BITS-1:0]        n_cur_y;
    logic signed [DELTA_BITS-1:0] dx;
    logic signed [DELTA_BITS-1:0] dy;
    logic signed [AW-1:0]         sum_x;
    logic signed [AW-1:0]         sum_y;

    always_comb begin
        dx = scaled_delta(i_pkt.header[HDR_XSIGN], i_pkt.header[HDR_XOVF],
                          i_pkt.x_move, i_cfg.sensitivity);
        dy = scaled_delta(i_pkt.header[HDR_YSIGN], i_pkt.header[HDR_YOVF],
                          i_pkt.y_move, i_cfg.sensitivity);
        // Screen y grows downward, so the mouse y delta is subtracted.
        sum_x = $signed({{(AW-COORD_BITS){1'b0}}, r_cur_x})
              + $signed({{(AW-DELTA_BITS){dx[DELTA_BITS-1]}}, dx});
        sum_y = $signed({{(AW-COORD_BITS){1'b0}}, r_cur_y})
              - $signed({{(AW-DELTA_BITS){dy[DELTA_BITS-1]}}, dy});
        n_cur_x = clamp_pos(sum_x, i_cfg.screen_width);
        n_cur_y = clamp_pos(sum_y, i_cfg.screen_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= X_RESET;
            r_cur_y <= Y_RESET;
        end else if (i_pkt.valid) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
        end
    end

    assign o_pos_x = n_cur_x;
    assign o_pos_y = n_cur_y;

endmodule

>>> rtl/core/ps2mt_out_skid.sv
// ----------------------------------------------------------------------------
// PS/2 mouse tracker output buffer
// Output register with a skid entry so the input side never waits on the
// output ready combinationally.
// ----------------------------------------------------------------------------
module ps2mt_out_skid #(
    parameter int WIDTH = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_ready
);

    logic             r_out_valid;
    logic             r_skid_valid;
    logic [WIDTH-1:0] r_out_data;
    logic [WIDTH-1:0] r_skid_data;
    logic             out_free;

    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                // Upstream is held while the skid entry is full.
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (i_valid) begin
            r_skid_data <= i_data;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

>>> rtl/core/ps2_mouse_packet_tracker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker
// Turns auxiliary-port bytes into clamped pointer positions and buttons.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one controller byte per transfer in tdata and
//   the auxiliary-source flag in tuser; bytes without the flag are dropped.
//   Every third accepted auxiliary byte of a synchronized packet produces one
//   transfer on the master stream: pos_x and pos_y in tdata, the left and
//   right buttons in tuser.
//   The result is registered in the output register, or in the skid entry
//   when the receiver stalls. One byte is accepted every cycle while tready
//   is high; the limit is the single cursor update path between the input
//   port and the output register.
//   After reset the packet phase is at the first byte, the cursor sits at
//   400,300 and the registers hold sensitivity 1 and an 800x600 screen.
//   When the receiver stalls, one result waits in the output register and a
//   second in a skid entry; tready drops only once the skid entry is full.
//   Configuration writes land on the clock edge where the write enable is high.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker
    import ps2mt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int M_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    // slave stream
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [7:0]               i_s_axis_tdata,   // [7:0] data_byte
    input  logic                     i_s_axis_tuser,   // [0] from_aux
    // master stream
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [M_DATA_BITS-1:0]   o_m_axis_tdata,   // pos_x, then pos_y, zero pad
    output logic [1:0]               o_m_axis_tuser    // [0] left button, [1] right button
);

    localparam int RES_BITS = 2 * COORD_BITS + 2;

    t_cfg                  cfg;
    t_packet               pkt;
    logic                  byte_valid;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [RES_BITS-1:0]   res_data;
    logic [RES_BITS-1:0]   out_data;

    assign byte_valid = i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser;

    ps2mt_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ps2mt_packet_asm u_packet_asm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (byte_valid),
        .i_byte       (i_s_axis_tdata),
        .o_pkt        (pkt)
    );

    ps2mt_cursor #(
        .COORD_BITS (COORD_BITS)
    ) u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt),
        .i_cfg   (cfg),
        .o_pos_x (pos_x),
        .o_pos_y (pos_y)
    );

    assign res_data = {pkt.header[HDR_RIGHT], pkt.header[HDR_LEFT], pos_y, pos_x};

    ps2mt_out_skid #(
        .WIDTH (RES_BITS)
    ) u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pkt.valid),
        .i_data  (res_data),
        .o_ready (o_s_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (out_data),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = M_DATA_BITS'(out_data[2*COORD_BITS-1:0]);
    assign o_m_axis_tuser = out_data[RES_BITS-1 -: 2];

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker testbench
// Feeds directed and random controller bytes through the tracker under several
// register settings, with bursty input and a stalling receiver. Each reported
// position and button pair is checked against a local cursor model.
// ----------------------------------------------------------------------------
module testbench;
    import ps2mt_pkg::*;

    localparam int COORD_BITS    = COORD_BITS_DEF;
    localparam int M_BITS        = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTED  = 10;
    localparam int PHASE_ITEMS   = 80;
    localparam int NUM_PHASES    = 7;

    // Index past the register list; the tracker must ignore writes to it.
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0] {PH_HEADER, PH_X_MOVE, PH_Y_MOVE} t_packet_phase;
    typedef enum int {RX_OPEN, RX_COIN, RX_THROTTLE, RX_PERIODIC} t_rx_mode;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  left;
        logic                  right;
    } t_pointer_report;

    class cursor_scoreboard;
        logic [SENS_BITS-1:0] sens;
        logic [SIZE_BITS-1:0] width;
        logic [SIZE_BITS-1:0] height;
        t_packet_phase        phase;
        logic [7:0]           header;
        logic [7:0]           x_move;
        int                   cur_x;
        int                   cur_y;
        t_pointer_report      expected_reports[$];
        int                   mismatches;

        function new();
            sens       = SENS_RESET;
            width      = WIDTH_RESET;
            height     = HEIGHT_RESET;
            phase      = PH_HEADER;
            header     = 8'h00;
            x_move     = 8'h00;
            cur_x      = CURSOR_X_RESET;
            cur_y      = CURSOR_Y_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                REG_SENSITIVITY:   sens = val[SENS_BITS-1:0];
                REG_SCREEN_WIDTH:  width = val[SIZE_BITS-1:0];
                REG_SCREEN_HEIGHT: height = val[SIZE_BITS-1:0];
                default: ;
            endcase
        endfunction

        static function int axis_delta(logic neg, logic ovf, logic [7:0] mv);
            if (ovf) return neg ? -255 : 255;
            return neg ? int'(mv) - 256 : int'(mv);
        endfunction

        // A zero size behaves as one, anything past the coordinate span as the span.
        static function int clamp_axis(int v, logic [SIZE_BITS-1:0] size_reg);
            int lim;
            if (size_reg == '0) lim = 1;
            else if (int'(size_reg) > (1 << COORD_BITS)) lim = 1 << COORD_BITS;
            else lim = int'(size_reg);
            if (v < 0) v = 0;
            if (v >= lim) v = lim - 1;
            return v;
        endfunction

        function void note_byte(logic [7:0] b, logic aux);
            int              mul;
            t_pointer_report r;
            if (!aux) return;
            case (phase)
                PH_X_MOVE: begin
                    x_move = b;
                    phase  = PH_Y_MOVE;
                end
                PH_Y_MOVE: begin
                    phase = PH_HEADER;
                    mul   = (sens == '0) ? 1 : int'(sens);
                    cur_x = clamp_axis(cur_x + mul * axis_delta(header[HDR_XSIGN],
                        header[HDR_XOVF], x_move), width);
                    cur_y = clamp_axis(cur_y - mul * axis_delta(header[HDR_YSIGN],
                        header[HDR_YOVF], b), height);
                    r.x     = COORD_BITS'(cur_x);
                    r.y     = COORD_BITS'(cur_y);
                    r.left  = header[HDR_LEFT];
                    r.right = header[HDR_RIGHT];
                    expected_reports.push_back(r);
                end
                default: begin
                    if (b[HDR_SYNC]) begin
                        header = b;
                        phase  = PH_X_MOVE;
                    end else begin
                        phase = PH_HEADER;
                    end
                end
            endcase
        endfunction

        function void check_report(logic [M_BITS-1:0] data, logic [1:0] user);
            t_pointer_report got;
            t_pointer_report want;
            got.x     = data[COORD_BITS-1:0];
            got.y     = data[2*COORD_BITS-1:COORD_BITS];
            got.left  = user[0];
            got.right = user[1];
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("unexpected report: x=%0d y=%0d left=%b right=%b",
                        got.x, got.y, got.left, got.right);
                return;
            end
            want = expected_reports.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.left !== want.left ||
                got.right !== want.right) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("mismatch: exp x=%0d y=%0d l=%b r=%b, got x=%0d y=%0d l=%b r=%b",
                        want.x, want.y, want.left, want.right,
                        got.x, got.y, got.left, got.right);
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata;
    logic                     i_s_axis_tvalid;
    logic                     o_s_axis_tready;
    logic [7:0]               i_s_axis_tdata;   // [7:0] data_byte
    logic                     i_s_axis_tuser;   // [0] from_aux
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready = 1'b0;
    logic [M_BITS-1:0]        o_m_axis_tdata;   // [11:0] pos_x, [23:12] pos_y
    logic [1:0]               o_m_axis_tuser;   // [0] left button, [1] right button

    cursor_scoreboard tracker;
    int               cycle_count = 0;
    int               burst_left = 0;
    t_rx_mode         rx_mode = RX_OPEN;
    int               rx_left = 0;

    ps2_mouse_packet_tracker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                tracker.note_byte(i_s_axis_tdata, i_s_axis_tuser);
            if (o_m_axis_tvalid && i_m_axis_tready)
                tracker.check_report(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    // The receiver switches between free running, coin flips, heavy throttling
    // and a fixed duty pattern, each for a random stretch.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(10, 150);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:     i_m_axis_tready <= 1'b1;
            RX_COIN:     i_m_axis_tready <= 1'($urandom_range(0, 1));
            RX_THROTTLE: i_m_axis_tready <= ($urandom_range(0, 5) == 0);
            default:     i_m_axis_tready <= (rx_left % 4 == 0);
        endcase
    end

    task automatic push_byte(input logic [7:0] b, input logic aux);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk) i_s_axis_tvalid <= 1'b0;
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= aux;
        do @(posedge i_clk); while (!o_s_axis_tready);
        burst_left--;
    endtask

    // Stops sending and waits until every pending report has been taken.
    task automatic drain();
        @(negedge i_clk) i_s_axis_tvalid <= 1'b0;
        while (tracker.expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk) i_cfg_we <= 1'b0;
        tracker.write_reg(idx, val);
    endtask

    // Half the moves are full random bytes, the rest small steps so the
    // cursor does not simply sit against an edge.
    function automatic logic [7:0] pick_move(logic neg);
        int k;
        if ($urandom_range(0, 1) == 0) return 8'($urandom);
        k = $urandom_range(0, 24);
        return neg ? 8'(256 - k) : 8'(k);
    endfunction

    task automatic send_packet();
        logic [7:0] pkt[3];
        pkt[0] = 8'($urandom);
        pkt[0][HDR_SYNC] = 1'b1;
        pkt[0][HDR_XOVF] = ($urandom_range(0, 7) == 0);
        pkt[0][HDR_YOVF] = ($urandom_range(0, 7) == 0);
        pkt[1] = pick_move(pkt[0][HDR_XSIGN]);
        pkt[2] = pick_move(pkt[0][HDR_YSIGN]);
        foreach (pkt[i]) begin
            if ($urandom_range(0, 9) == 0) push_byte(8'($urandom), 1'b0);
            push_byte(pkt[i], 1'b1);
        end
    endtask

    initial begin
        int sent;
        int sens_set[NUM_PHASES];
        int width_set[NUM_PHASES];
        int height_set[NUM_PHASES];

        sens_set   = '{15, 0, 1, 7, 0, 3, 15};
        width_set  = '{4096, 0, 8191, 1, 0, 640, 100};
        height_set = '{4096, 1, 8191, 0, 0, 480, 5000};
        sens_set[4]   = $urandom_range(0, 15);
        width_set[4]  = $urandom_range(1, 4096);
        height_set[4] = $urandom_range(1, 4096);

        tracker         = new();
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = '0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Reset settings: ignored and unsynchronized bytes, then deltas at
        // their extremes, both signs, overflow and every button pattern.
        push_byte(8'h08, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hF7, 1'b1);
        push_byte(8'h08, 1'b1); push_byte(8'hFF, 1'b1); push_byte(8'h00, 1'b1);
        push_byte(8'h09, 1'b1); push_byte(8'h01, 1'b1);
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b1);
        push_byte(8'h3A, 1'b1); push_byte(8'h00, 1'b1); push_byte(8'h00, 1'b1);
        push_byte(8'hFB, 1'b1); push_byte(8'h00, 1'b1); push_byte(8'hFF, 1'b1);
        push_byte(8'h4B, 1'b1); push_byte(8'h00, 1'b1); push_byte(8'h80, 1'b1);
        push_byte(8'h88, 1'b1); push_byte(8'h7F, 1'b1); push_byte(8'h00, 1'b1);
        push_byte(8'h18, 1'b1); push_byte(8'h01, 1'b1); push_byte(8'hFF, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            if (p == 5) write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));
            write_reg(REG_SENSITIVITY, CFG_DATA_BITS'(sens_set[p]));
            write_reg(REG_SCREEN_WIDTH, CFG_DATA_BITS'(width_set[p]));
            write_reg(REG_SCREEN_HEIGHT, CFG_DATA_BITS'(height_set[p]));
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_byte(8'($urandom), 1'b1);
                    sent += 1;
                end else begin
                    send_packet();
                    sent += 3;
                end
            end
        end

        drain();
        if (tracker.mismatches == 0 && tracker.expected_reports.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
